@@ rtl/ssc_pkg.sv @@
// Shared definitions for the stack sequence checker.
// Holds default sizes, the sequencer state type and the engine status word.
package ssc_pkg;

  localparam int unsigned MaxLenDef    = 1024;
  localparam int unsigned ValueBitsDef = 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CMP,
    ST_FINISH
  } ssc_state_e;

  typedef struct packed {
    logic idle;
    logic res_valid;
    logic res_value;
  } ssc_status_t;

endpackage

@@ rtl/stack_sequence_checker_top.sv @@
// Top level of the stack sequence checker: input handshake and result register.
// Depends on ssc_pkg and ssc_engine.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid_i, in_ready_o, push_value_i,          | in
//          | pop_value_i, last_i                            |
//  output  | out_valid_o, out_ready_i, valid_sequence_o     | out
//
// A word runs IDLE, CHECK, then CMP and CHECK per value popped, plus one CMP when the
// stack top does not match the buffered pop value, then FINISH; a word past the length
// limit goes from IDLE to FINISH, and FINISH holds a last word until the output has room.
// After reset the block is ready at once; the memories are not cleared.
// A pending result may wait in the output register while the next word is taken.
module stack_sequence_checker_top import ssc_pkg::*; #(
  parameter int unsigned MAX_LEN    = MaxLenDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] push_value_i,
  input  logic [VALUE_BITS-1:0] pop_value_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  valid_sequence_o
);

  ssc_status_t eng_status;
  logic        out_valid_q, out_valid_d;
  logic        result_q, result_d;
  logic        slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = eng_status.idle;

  ssc_engine #(.MAX_LEN(MAX_LEN), .VALUE_BITS(VALUE_BITS)) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_valid_i && in_ready_o),
    .push_value_i (push_value_i),
    .pop_value_i  (pop_value_i),
    .last_i       (last_i),
    .slot_free_i  (slot_free),
    .status_o     (eng_status)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (eng_status.res_valid) begin
      out_valid_d = 1'b1;
      result_d    = eng_status.res_value;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o      = out_valid_q;
  assign valid_sequence_o = result_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after an accepted word");

  a_result_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_status.res_valid |-> (!out_valid_q || out_ready_i))
    else $error("result produced while output register is occupied");

  a_output_from_engine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(eng_status.res_valid))
    else $error("output valid rose without an engine result");

endmodule

@@ rtl/ssc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssc_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ssc_engine.sv @@
// Sequencer, counters and the shared compare unit of the stack sequence checker.
// Depends on ssc_pkg and ssc_ram (stack memory and pop buffer).
module ssc_engine import ssc_pkg::*; #(
  parameter int unsigned MAX_LEN    = MaxLenDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] push_value_i,
  input  logic [VALUE_BITS-1:0] pop_value_i,
  input  logic                  last_i,
  input  logic                  slot_free_i,
  output ssc_status_t           status_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_LEN);

  ssc_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, wr_q, wr_d, rd_q, rd_d;
  logic          ovf_q, ovf_d, last_q, last_d;
  logic          we;
  logic [CW-1:0] cnt_m1;
  logic [VALUE_BITS-1:0] stk_rdata, pop_rdata;

  assign cnt_m1 = cnt_q - 1'b1;

  ssc_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LEN)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (push_value_i),
    .raddr_i (cnt_m1[AW-1:0]),
    .rdata_o (stk_rdata)
  );

  ssc_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LEN)) u_pop_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_q[AW-1:0]),
    .wdata_i (pop_value_i),
    .raddr_i (rd_q[AW-1:0]),
    .rdata_o (pop_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    wr_d     = wr_q;
    rd_d     = rd_q;
    ovf_d    = ovf_q;
    last_d   = last_q;
    we       = 1'b0;
    status_o = '{idle: 1'b0, res_valid: 1'b0, res_value: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        status_o.idle = 1'b1;
        if (start_i) begin
          last_d = last_i;
          if (ovf_q || (wr_q == MaxCount)) begin
            ovf_d   = 1'b1;
            state_d = ST_FINISH;
          end else begin
            we      = 1'b1;
            cnt_d   = cnt_q + 1'b1;
            wr_d    = wr_q + 1'b1;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if ((cnt_q != '0) && (rd_q < wr_q)) begin
          state_d = ST_CMP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_CMP: begin
        if (stk_rdata == pop_rdata) begin
          cnt_d   = cnt_m1;
          rd_d    = rd_q + 1'b1;
          state_d = ST_CHECK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (slot_free_i) begin
          status_o.res_valid = 1'b1;
          status_o.res_value = !ovf_q && (cnt_q == '0);
          cnt_d   = '0;
          wr_d    = '0;
          rd_d    = '0;
          ovf_d   = 1'b0;
          last_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
